### hw/rtl/topa_pkg.sv
// shared types and constants for the tile outer product accumulator
package topa_pkg;

   localparam int TILE       = 4;
   localparam int CELLS      = TILE * TILE;
   localparam int IN_W       = 16;
   localparam int PROD_W     = 2 * IN_W;
   localparam int ACC_W      = 48;
   localparam int IDX_W      = $clog2(CELLS);
   localparam int POS_W      = $clog2(TILE);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(CELLS - 1);

   typedef struct packed {
      logic signed [IN_W-1:0] a_row0;
      logic signed [IN_W-1:0] a_row1;
      logic signed [IN_W-1:0] a_row2;
      logic signed [IN_W-1:0] a_row3;
      logic signed [IN_W-1:0] b_col0;
      logic signed [IN_W-1:0] b_col1;
      logic signed [IN_W-1:0] b_col2;
      logic signed [IN_W-1:0] b_col3;
      logic                   inner_last;
   } req_payload_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] sum_value;
      logic [POS_W-1:0]        tile_row;
      logic [POS_W-1:0]        tile_col;
      logic                    saturated;
      logic                    tile_done;
   } rsp_payload_type;

   // common controls broadcast to every cell
   typedef struct packed {
      logic prod_en;
      logic acc_en;
      logic capture;
      logic shift;
   } cell_ctrl_type;

endpackage

### hw/rtl/topa_channel_if.sv
// valid/ready channel carrying one payload struct
interface topa_channel_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/tile_outer_product_accumulator.sv
// 4x4 outer product accumulator: one A column and B row per cycle while accumulating.
// an item is multiplied as it transfers and added to the accumulators in the next cycle.
// the first of 16 results is valid after the inner_last product is summed into the drain
// stage; results drain through the cell chain at one per cycle while rsp is ready,
// and the next item is taken the cycle after the sixteenth result transfers.
// reset clears the accumulators, clip flags and drain control, not the drain shift stages.
module tile_outer_product_accumulator (
   input  logic             clock,
   input  logic             reset,
   topa_channel_if.sink     req,
   topa_channel_if.source   rsp
);

   logic signed [topa_pkg::IN_W-1:0]  a_vec [topa_pkg::TILE];
   logic signed [topa_pkg::IN_W-1:0]  b_vec [topa_pkg::TILE];
   logic signed [topa_pkg::ACC_W-1:0] chain_sum  [topa_pkg::CELLS+1];
   logic                              chain_flag [topa_pkg::CELLS+1];

   logic                           pvalid_ff, pvalid_in;
   logic                           plast_ff, plast_in;
   logic                           busy_ff, busy_in;
   logic                           out_valid_ff, out_valid_in;
   logic [topa_pkg::IDX_W-1:0]     cnt_ff, cnt_in;
   logic                           accept, rsp_xfer, final_xfer;
   topa_pkg::cell_ctrl_type        ctrl;

   assign a_vec[0] = req.payload.a_row0;
   assign a_vec[1] = req.payload.a_row1;
   assign a_vec[2] = req.payload.a_row2;
   assign a_vec[3] = req.payload.a_row3;
   assign b_vec[0] = req.payload.b_col0;
   assign b_vec[1] = req.payload.b_col1;
   assign b_vec[2] = req.payload.b_col2;
   assign b_vec[3] = req.payload.b_col3;

   assign req.ready  = !busy_ff;
   assign accept     = req.valid && !busy_ff;
   assign rsp_xfer   = out_valid_ff && rsp.ready;
   assign final_xfer = rsp_xfer && (cnt_ff == topa_pkg::LAST_IDX);

   always_comb begin
      pvalid_in    = accept;
      plast_in     = accept && req.payload.inner_last;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      cnt_in       = cnt_ff;
      if (plast_in) begin
         busy_in = 1'b1;
      end else if (final_xfer) begin
         busy_in = 1'b0;
      end
      if (pvalid_ff && plast_ff) begin
         out_valid_in = 1'b1;
      end else if (final_xfer) begin
         out_valid_in = 1'b0;
      end
      if (rsp_xfer) begin
         cnt_in = cnt_ff + 1'b1;
      end
      ctrl.prod_en = accept;
      ctrl.acc_en  = pvalid_ff;
      ctrl.capture = plast_ff;
      ctrl.shift   = rsp_xfer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff    <= 1'b0;
         plast_ff     <= 1'b0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         pvalid_ff    <= pvalid_in;
         plast_ff     <= plast_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // end of the drain chain feeds zeros
   assign chain_sum[topa_pkg::CELLS]  = '0;
   assign chain_flag[topa_pkg::CELLS] = 1'b0;

   // cell i holds element col = i / 4, row = i % 4, so the chain drains column-major
   for (genvar i = 0; i < topa_pkg::CELLS; i++) begin : g_cell
      topa_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .a_in           (a_vec[i % topa_pkg::TILE]),
         .b_in           (b_vec[i / topa_pkg::TILE]),
         .shift_sum_in   (chain_sum[i+1]),
         .shift_flag_in  (chain_flag[i+1]),
         .shift_sum_out  (chain_sum[i]),
         .shift_flag_out (chain_flag[i])
      );
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.payload.sum_value = chain_sum[0];
   assign rsp.payload.tile_row  = cnt_ff[topa_pkg::POS_W-1:0];
   assign rsp.payload.tile_col  = cnt_ff[topa_pkg::IDX_W-1:topa_pkg::POS_W];
   assign rsp.payload.saturated = chain_flag[0];
   assign rsp.payload.tile_done = cnt_ff == topa_pkg::LAST_IDX;

endmodule

### hw/rtl/topa_cell.sv
// one tile element: product register, saturating accumulator and drain shift stage
module topa_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  topa_pkg::cell_ctrl_type              ctrl,
   input  logic signed [topa_pkg::IN_W-1:0]     a_in,
   input  logic signed [topa_pkg::IN_W-1:0]     b_in,
   input  logic signed [topa_pkg::ACC_W-1:0]    shift_sum_in,
   input  logic                                 shift_flag_in,
   output logic signed [topa_pkg::ACC_W-1:0]    shift_sum_out,
   output logic                                 shift_flag_out
);

   logic signed [topa_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [topa_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                               clip_ff, clip_in;
   logic signed [topa_pkg::ACC_W-1:0]  shift_sum_ff, shift_sum_in_nxt;
   logic                               shift_flag_ff, shift_flag_in_nxt;
   logic signed [topa_pkg::ACC_W:0]    wide_sum;
   logic signed [topa_pkg::ACC_W-1:0]  sat_sum;
   logic                               over;

   assign prod_in = a_in * b_in;

   always_comb begin
      wide_sum = (topa_pkg::ACC_W + 1)'(acc_ff) + (topa_pkg::ACC_W + 1)'(prod_ff);
      over     = wide_sum[topa_pkg::ACC_W] != wide_sum[topa_pkg::ACC_W-1];
      if (!over) begin
         sat_sum = wide_sum[topa_pkg::ACC_W-1:0];
      end else if (wide_sum[topa_pkg::ACC_W]) begin
         sat_sum = topa_pkg::ACC_MIN;
      end else begin
         sat_sum = topa_pkg::ACC_MAX;
      end

      acc_in            = acc_ff;
      clip_in           = clip_ff;
      shift_sum_in_nxt  = shift_sum_ff;
      shift_flag_in_nxt = shift_flag_ff;
      if (ctrl.acc_en) begin
         if (ctrl.capture) begin
            // final step of the tile goes straight into the drain stage
            shift_sum_in_nxt  = sat_sum;
            shift_flag_in_nxt = clip_ff | over;
            acc_in            = '0;
            clip_in           = 1'b0;
         end else begin
            acc_in  = sat_sum;
            clip_in = clip_ff | over;
         end
      end else if (ctrl.shift) begin
         shift_sum_in_nxt  = shift_sum_in;
         shift_flag_in_nxt = shift_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         clip_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         clip_ff <= clip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_en) begin
         prod_ff <= prod_in;
      end
      shift_sum_ff  <= shift_sum_in_nxt;
      shift_flag_ff <= shift_flag_in_nxt;
   end

   assign shift_sum_out  = shift_sum_ff;
   assign shift_flag_out = shift_flag_ff;

endmodule
